FILE: sv/pcdg_pkg.sv
// Shared types and constants of the plane-change deadband gate.
package pcdg_pkg;

  localparam int unsigned INTERCEPT_W = 24;
  localparam int unsigned SLOPE_W     = 20;
  localparam int unsigned COORD_W     = 14;
  localparam int unsigned DELTA_W     = 24;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned SLOT_W      = 4;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 24;

  // Difference terms and the running sum; the sum is in units of 2^-12 of an intercept step.
  localparam int unsigned DI_W   = INTERCEPT_W + 1;
  localparam int unsigned DS_W   = SLOPE_W + 1;
  localparam int unsigned PROD_W = DS_W + COORD_W;
  localparam int unsigned ACC_W  = 40;
  localparam int unsigned FRAC_W = 12;

  // Largest number of table slots in use; larger point_count values are clamped to it.
  localparam int unsigned SLOT_CAP = 16;

  typedef enum logic [1:0] {
    OP_OBSERVE = 2'd0,
    OP_LOAD    = 2'd1,
    OP_RESET   = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ACT_NONE      = 2'd0,
    ACT_FAIL_OPEN = 2'd1,
    ACT_RECALC    = 2'd2,
    ACT_REFRESH   = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEADBAND    = 1'd0,
    CFG_POINT_COUNT = 1'd1
  } cfg_reg_t;

  localparam logic [DELTA_W-1:0]    DELTA_MAX     = {DELTA_W{1'b1}};
  localparam logic [COUNT_W-1:0]    POINT_COUNT_RST = 5'd4;

endpackage

FILE: sv/plane_change_deadband_gate_unit.sv
// Plane-change deadband gate: reference plane, point table and delta sequencer.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------------------
//   in      | input     | in_valid / in_stall | opcode, cand_*, point_index, point_x/y
//   out     | output    | out_valid/out_stall | action, max_delta, delta_saturated
//   cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Load, reset, undefined and trivial observe items set finish on transfer and then move to
// the output register once it is free. A candidate that needs a delta runs S_SETUP, then
// per point in use one table read, two passes through the shared multiplier, a sum step
// and a round-and-compare step, then S_DECIDE. rst is synchronous; it clears the reference
// plane, configuration and control state, not the point table. in_stall is high while an
// item is in work or waits for the output register, but not while a result sits there.
module plane_change_deadband_gate_unit #(
  parameter int unsigned NUM_POINTS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input items
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           opcode,
  input  logic                                 cand_valid,
  input  logic signed [pcdg_pkg::INTERCEPT_W-1:0] cand_intercept,
  input  logic signed [pcdg_pkg::SLOPE_W-1:0]  cand_slope_x,
  input  logic signed [pcdg_pkg::SLOPE_W-1:0]  cand_slope_y,
  input  logic [pcdg_pkg::SLOT_W-1:0]          point_index,
  input  logic signed [pcdg_pkg::COORD_W-1:0]  point_x,
  input  logic signed [pcdg_pkg::COORD_W-1:0]  point_y,
  // results
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           action,
  output logic [pcdg_pkg::DELTA_W-1:0]         max_delta,
  output logic                                 delta_saturated,
  // configuration
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pcdg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pcdg_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int unsigned AW = $clog2(NUM_POINTS);
  localparam int unsigned SLOT_LIMIT =
    (NUM_POINTS < pcdg_pkg::SLOT_CAP) ? NUM_POINTS : pcdg_pkg::SLOT_CAP;
  localparam int unsigned CW = pcdg_pkg::COORD_W;
  localparam int unsigned RW = 2 * CW;
  localparam int unsigned IW = pcdg_pkg::INTERCEPT_W;
  localparam int unsigned SW = pcdg_pkg::SLOPE_W;
  localparam int unsigned AccW = pcdg_pkg::ACC_W;
  localparam int unsigned PW = pcdg_pkg::PROD_W;
  localparam int unsigned DW = pcdg_pkg::DELTA_W;
  localparam int unsigned KW = pcdg_pkg::COUNT_W;
  localparam int unsigned FRAC_W_L = pcdg_pkg::FRAC_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_RD,
    S_MULX,
    S_MULY,
    S_SUM,
    S_EVAL,
    S_DECIDE
  } state_t;

  state_t state;
  logic   finish;

  // Configuration registers.
  logic [DW-1:0] deadband;
  logic [KW-1:0] point_count;

  // Reference plane and captured candidate.
  logic                 have_ref;
  logic signed [IW-1:0] ref_intercept;
  logic signed [SW-1:0] ref_slope_x;
  logic signed [SW-1:0] ref_slope_y;
  logic signed [IW-1:0] cand_i;
  logic signed [SW-1:0] cand_x;
  logic signed [SW-1:0] cand_y;

  // Datapath.
  logic signed [pcdg_pkg::DI_W-1:0] diff_i;
  logic signed [pcdg_pkg::DS_W-1:0] diff_x;
  logic signed [pcdg_pkg::DS_W-1:0] diff_y;
  logic signed [PW-1:0]             prod;
  logic signed [AccW-1:0]           acc;
  logic [KW-1:0]                    k;
  logic [KW-1:0]                    cnt;

  // Result being built.
  logic [1:0]    res_action;
  logic [DW-1:0] res_maxd;
  logic          res_sat;

  logic          in_accept;
  logic          out_free;
  logic          ram_we;
  logic [RW-1:0] ram_rdata;
  logic signed [CW-1:0] tab_x;
  logic signed [CW-1:0] tab_y;

  logic signed [pcdg_pkg::DS_W-1:0] mul_a;
  logic signed [CW-1:0]             mul_b;
  logic signed [PW-1:0]             mul_p;
  logic [AccW-1:0]                  rnd;
  logic [AccW-FRAC_W_L-1:0]         rq;
  logic                             over;
  logic [DW-1:0]                    r_cl;
  logic [KW-1:0]                    cnt_lim;
  logic [KW-1:0]                    k_inc;

  assign in_stall  = (state != S_IDLE) || finish;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;

  assign ram_we = in_accept && (opcode == pcdg_pkg::OP_LOAD) &&
                  (32'(point_index) < NUM_POINTS);

  pcdg_ram #(
    .WIDTH (RW),
    .DEPTH (NUM_POINTS)
  ) u_points (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(point_index)),
    .wdata ({point_x, point_y}),
    .raddr (AW'(k)),
    .rdata (ram_rdata)
  );

  assign tab_x = ram_rdata[RW-1:CW];
  assign tab_y = ram_rdata[CW-1:0];

  // One shared multiplier: X term in S_MULX, Y term in S_MULY.
  assign mul_a = (state == S_MULX) ? diff_x : diff_y;
  assign mul_b = (state == S_MULX) ? tab_x : tab_y;
  assign mul_p = mul_a * mul_b;

  // Magnitude rounded half up in one add: for negative d, -d + 2048 == ~d + 2049.
  assign rnd  = acc[AccW-1] ? (~acc + AccW'(2049)) : (acc + AccW'(2048));
  assign rq   = rnd[AccW-1:FRAC_W_L];
  assign over = |rq[AccW-FRAC_W_L-1:DW];
  assign r_cl = over ? pcdg_pkg::DELTA_MAX : rq[DW-1:0];

  assign cnt_lim = (point_count > KW'(SLOT_LIMIT)) ? KW'(SLOT_LIMIT) : point_count;
  assign k_inc   = k + KW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband    <= '0;
      point_count <= pcdg_pkg::POINT_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pcdg_pkg::CFG_DEADBAND:    deadband    <= cfg_data[DW-1:0];
        pcdg_pkg::CFG_POINT_COUNT: point_count <= cfg_data[KW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      finish        <= 1'b0;
      have_ref      <= 1'b0;
      ref_intercept <= '0;
      ref_slope_x   <= '0;
      ref_slope_y   <= '0;
      out_valid     <= 1'b0;
    end else begin
      // A finished result moves to the output register once that is free.
      if (finish && out_free) begin
        finish          <= 1'b0;
        out_valid       <= 1'b1;
        action          <= res_action;
        max_delta       <= res_maxd;
        delta_saturated <= res_sat;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_accept) begin
            res_maxd <= '0;
            res_sat  <= 1'b0;
            cand_i   <= cand_intercept;
            cand_x   <= cand_slope_x;
            cand_y   <= cand_slope_y;
            case (opcode)
              pcdg_pkg::OP_RESET: begin
                have_ref      <= 1'b0;
                ref_intercept <= '0;
                ref_slope_x   <= '0;
                ref_slope_y   <= '0;
                res_action    <= pcdg_pkg::ACT_NONE;
                finish        <= 1'b1;
              end
              pcdg_pkg::OP_OBSERVE: begin
                if (!cand_valid) begin
                  if (have_ref) begin
                    have_ref      <= 1'b0;
                    ref_intercept <= '0;
                    ref_slope_x   <= '0;
                    ref_slope_y   <= '0;
                    res_action    <= pcdg_pkg::ACT_FAIL_OPEN;
                  end else begin
                    res_action <= pcdg_pkg::ACT_NONE;
                  end
                  finish <= 1'b1;
                end else if (!have_ref) begin
                  have_ref      <= 1'b1;
                  ref_intercept <= cand_intercept;
                  ref_slope_x   <= cand_slope_x;
                  ref_slope_y   <= cand_slope_y;
                  res_action    <= pcdg_pkg::ACT_RECALC;
                  finish        <= 1'b1;
                end else begin
                  state <= S_SETUP;
                end
              end
              default: begin
                res_action <= pcdg_pkg::ACT_NONE;
                finish     <= 1'b1;
              end
            endcase
          end
        end
        S_SETUP: begin
          diff_i <= {cand_i[IW-1], cand_i} - {ref_intercept[IW-1], ref_intercept};
          diff_x <= {cand_x[SW-1], cand_x} - {ref_slope_x[SW-1], ref_slope_x};
          diff_y <= {cand_y[SW-1], cand_y} - {ref_slope_y[SW-1], ref_slope_y};
          k      <= '0;
          cnt    <= cnt_lim;
          state  <= (cnt_lim == '0) ? S_DECIDE : S_RD;
        end
        S_RD: begin
          state <= S_MULX;
        end
        S_MULX: begin
          prod  <= mul_p;
          state <= S_MULY;
        end
        S_MULY: begin
          prod  <= mul_p;
          acc   <= {{3{diff_i[pcdg_pkg::DI_W-1]}}, diff_i, {FRAC_W_L{1'b0}}} +
                   {{(AccW-PW){prod[PW-1]}}, prod};
          state <= S_SUM;
        end
        S_SUM: begin
          acc   <= acc + {{(AccW-PW){prod[PW-1]}}, prod};
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (over) begin
            res_sat <= 1'b1;
          end
          if (r_cl > res_maxd) begin
            res_maxd <= r_cl;
          end
          k     <= k_inc;
          state <= (k_inc == cnt) ? S_DECIDE : S_RD;
        end
        S_DECIDE: begin
          if (res_sat || (res_maxd >= deadband)) begin
            ref_intercept <= cand_i;
            ref_slope_x   <= cand_x;
            ref_slope_y   <= cand_y;
            res_action    <= pcdg_pkg::ACT_RECALC;
          end else begin
            res_action <= pcdg_pkg::ACT_REFRESH;
          end
          finish <= 1'b1;
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_sat_is_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && delta_saturated |-> max_delta == pcdg_pkg::DELTA_MAX)
    else $error("saturated result without full-scale delta");

  a_no_delta_on_none: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action == pcdg_pkg::ACT_NONE || action == pcdg_pkg::ACT_FAIL_OPEN)
    |-> max_delta == '0 && !delta_saturated)
    else $error("delta reported for an item that computes none");

  a_point_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_RD |-> k < cnt && cnt <= KW'(SLOT_LIMIT))
    else $error("point walk beyond the points in use");

  a_first_valid_takes_ref: assert property (@(posedge clk) disable iff (rst)
    in_accept && opcode == pcdg_pkg::OP_OBSERVE && cand_valid && !have_ref
    |=> have_ref && res_action == pcdg_pkg::ACT_RECALC)
    else $error("first valid candidate not taken as reference");

  a_ram_write_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> finish && state == S_IDLE)
    else $error("table load did not finish at once");
`endif

endmodule

FILE: sv/pcdg_ram.sv
// Generic single-port-write, registered-read RAM.
module pcdg_ram #(
  parameter int unsigned WIDTH = 28,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: tb/sv/tb_plane_change_deadband_gate_unit.sv
// Self-checking testbench for the plane-change deadband gate: directed table, then random phases.
module tb_plane_change_deadband_gate_unit;

  localparam int unsigned NUM_PTS = 16;
  localparam int unsigned TABLE_SLOTS =
    (NUM_PTS < pcdg_pkg::SLOT_CAP) ? NUM_PTS : pcdg_pkg::SLOT_CAP;
  localparam int unsigned DW = pcdg_pkg::DELTA_W;
  localparam int unsigned CDW = pcdg_pkg::CFG_DATA_W;
  localparam logic [1:0] OP_UNDEFINED = 2'd3;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS = 150;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    logic [1:0]                               op;
    logic                                     cvalid;
    logic signed [pcdg_pkg::INTERCEPT_W-1:0]  ci;
    logic signed [pcdg_pkg::SLOPE_W-1:0]      sx;
    logic signed [pcdg_pkg::SLOPE_W-1:0]      sy;
    logic [pcdg_pkg::SLOT_W-1:0]              slot;
    logic signed [pcdg_pkg::COORD_W-1:0]      px;
    logic signed [pcdg_pkg::COORD_W-1:0]      py;
  } gate_item_t;

  typedef struct packed {
    pcdg_pkg::action_t    act;
    logic [DW-1:0]        delta;
    logic                 sat;
  } gate_verdict_t;

  typedef struct {
    bit                    is_cfg;
    pcdg_pkg::cfg_reg_t    reg_idx;
    logic [CDW-1:0]        reg_val;
    gate_item_t            it;
    bit                    fixed;
    gate_verdict_t         want;
  } dir_row_t;

  localparam int unsigned ITEM_W = $bits(gate_item_t);

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [1:0] opcode;
  logic cand_valid;
  logic signed [pcdg_pkg::INTERCEPT_W-1:0] cand_intercept;
  logic signed [pcdg_pkg::SLOPE_W-1:0] cand_slope_x;
  logic signed [pcdg_pkg::SLOPE_W-1:0] cand_slope_y;
  logic [pcdg_pkg::SLOT_W-1:0] point_index;
  logic signed [pcdg_pkg::COORD_W-1:0] point_x;
  logic signed [pcdg_pkg::COORD_W-1:0] point_y;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] action;
  logic [DW-1:0] max_delta;
  logic delta_saturated;
  logic cfg_valid;
  logic cfg_ready;
  logic [pcdg_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [CDW-1:0] cfg_data;

  plane_change_deadband_gate_unit #(
    .NUM_POINTS(NUM_PTS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .cand_valid(cand_valid),
    .cand_intercept(cand_intercept),
    .cand_slope_x(cand_slope_x),
    .cand_slope_y(cand_slope_y),
    .point_index(point_index),
    .point_x(point_x),
    .point_y(point_y),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .action(action),
    .max_delta(max_delta),
    .delta_saturated(delta_saturated),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow copy of the gate: accepted plane, point table and registers.
  bit plane_held;
  longint plane_ci, plane_sx, plane_sy;
  longint tab_x [NUM_PTS];
  longint tab_y [NUM_PTS];
  logic [15:0] slot_loaded;
  logic [DW-1:0] db_reg;
  logic [pcdg_pkg::COUNT_W-1:0] npts_reg;

  gate_verdict_t pending_verdicts[$];
  dir_row_t dir_rows[$];
  int mismatches;
  int items_sent;
  int reg_writes;
  int act_tally [4];
  int sat_tally;
  bit quiet;
  int rx_hold;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Timeout: results still outstanding: %0d", pending_verdicts.size());
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [DW-1:0] got,
                                 input logic [DW-1:0] want);
    mismatches++;
    $display("MISMATCH at %0t: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  function automatic void clear_plane();
    plane_held = 1'b0;
    plane_ci = 0;
    plane_sx = 0;
    plane_sy = 0;
  endfunction

  function automatic int points_in_use();
    return (npts_reg > TABLE_SLOTS) ? TABLE_SLOTS : int'(npts_reg);
  endfunction

  // Works out the result of one item and advances the shadow state.
  function automatic gate_verdict_t plane_gate_step(gate_item_t it);
    gate_verdict_t v;
    longint ci, sx, sy, d, mag, r, worst;
    int n, k;
    v.act = pcdg_pkg::ACT_NONE;
    v.delta = '0;
    v.sat = 1'b0;
    ci = $signed(it.ci);
    sx = $signed(it.sx);
    sy = $signed(it.sy);
    worst = 0;
    if (it.op == pcdg_pkg::OP_LOAD) begin
      if (it.slot < NUM_PTS) begin
        tab_x[it.slot] = $signed(it.px);
        tab_y[it.slot] = $signed(it.py);
        slot_loaded[it.slot] = 1'b1;
      end
    end else if (it.op == pcdg_pkg::OP_RESET) begin
      clear_plane();
    end else if (it.op == pcdg_pkg::OP_OBSERVE) begin
      if (!it.cvalid) begin
        if (plane_held) begin
          clear_plane();
          v.act = pcdg_pkg::ACT_FAIL_OPEN;
        end
      end else if (!plane_held) begin
        plane_held = 1'b1;
        plane_ci = ci;
        plane_sx = sx;
        plane_sy = sy;
        v.act = pcdg_pkg::ACT_RECALC;
      end else begin
        n = points_in_use();
        for (k = 0; k < n; k++) begin
          d = (ci - plane_ci) * 4096 + (sx - plane_sx) * tab_x[k] + (sy - plane_sy) * tab_y[k];
          mag = (d < 0) ? -d : d;
          r = (mag + 2048) >> 12;
          if (r > longint'(pcdg_pkg::DELTA_MAX)) begin
            r = longint'(pcdg_pkg::DELTA_MAX);
            v.sat = 1'b1;
          end
          if (r > worst) worst = r;
        end
        v.delta = worst[DW-1:0];
        if (v.sat || worst >= longint'(db_reg)) begin
          plane_ci = ci;
          plane_sx = sx;
          plane_sy = sy;
          v.act = pcdg_pkg::ACT_RECALC;
        end else begin
          v.act = pcdg_pkg::ACT_REFRESH;
        end
      end
    end
    return v;
  endfunction

  // Random item, mostly candidates near the held plane so deltas land around the deadband.
  function automatic gate_item_t draw_item();
    gate_item_t it;
    logic [ITEM_W-1:0] raw;
    logic [15:0] need;
    longint base;
    int pick, dv, n, k;
    raw = ITEM_W'({$urandom, $urandom, $urandom, $urandom});
    it = raw;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      it.op = pcdg_pkg::OP_OBSERVE;
      it.cvalid = 1'b1;
      if (plane_held && $urandom_range(0, 9) != 0) begin
        dv = $urandom_range(0, 4000);
        base = plane_ci + dv - 2000;
        it.ci = base[pcdg_pkg::INTERCEPT_W-1:0];
        dv = $urandom_range(0, 128);
        base = plane_sx + dv - 64;
        it.sx = base[pcdg_pkg::SLOPE_W-1:0];
        dv = $urandom_range(0, 128);
        base = plane_sy + dv - 64;
        it.sy = base[pcdg_pkg::SLOPE_W-1:0];
      end
    end else if (pick < 65) begin
      it.op = pcdg_pkg::OP_OBSERVE;
      it.cvalid = 1'b0;
    end else if (pick < 80) begin
      it.op = pcdg_pkg::OP_LOAD;
      if ($urandom_range(0, 3) == 0) begin
        it.px = $urandom_range(0, 1) ? 14'h1fff : 14'h2000;
        it.py = $urandom_range(0, 1) ? 14'h1fff : 14'h2000;
      end
    end else if (pick < 85) begin
      it.op = pcdg_pkg::OP_RESET;
    end else if (pick < 88) begin
      it.op = OP_UNDEFINED;
    end
    // A delta must never read a table slot that has not been loaded yet.
    n = points_in_use();
    need = 16'((32'd1 << n) - 1);
    if (it.op == pcdg_pkg::OP_OBSERVE && it.cvalid && plane_held &&
        (slot_loaded & need) != need) begin
      it.op = pcdg_pkg::OP_LOAD;
      for (k = n - 1; k >= 0; k--) begin
        if (!slot_loaded[k]) it.slot = k[pcdg_pkg::SLOT_W-1:0];
      end
    end
    return it;
  endfunction

  function automatic dir_row_t blank_row();
    dir_row_t row;
    row.is_cfg = 1'b0;
    row.reg_idx = pcdg_pkg::CFG_DEADBAND;
    row.reg_val = '0;
    row.it = '0;
    row.fixed = 1'b0;
    row.want = '{act: pcdg_pkg::ACT_NONE, delta: '0, sat: 1'b0};
    return row;
  endfunction

  function automatic dir_row_t cand_row(bit v, int ci, int sx, int sy, bit fixed,
                                        pcdg_pkg::action_t a, logic [DW-1:0] d, bit s);
    dir_row_t row;
    row = blank_row();
    row.it.op = pcdg_pkg::OP_OBSERVE;
    row.it.cvalid = v;
    row.it.ci = ci[pcdg_pkg::INTERCEPT_W-1:0];
    row.it.sx = sx[pcdg_pkg::SLOPE_W-1:0];
    row.it.sy = sy[pcdg_pkg::SLOPE_W-1:0];
    row.fixed = fixed;
    row.want = '{act: a, delta: d, sat: s};
    return row;
  endfunction

  function automatic dir_row_t load_row(int slot, int px, int py);
    dir_row_t row;
    row = blank_row();
    row.it.op = pcdg_pkg::OP_LOAD;
    row.it.slot = slot[pcdg_pkg::SLOT_W-1:0];
    row.it.px = px[pcdg_pkg::COORD_W-1:0];
    row.it.py = py[pcdg_pkg::COORD_W-1:0];
    row.fixed = 1'b1;
    return row;
  endfunction

  function automatic dir_row_t code_row(logic [1:0] op);
    dir_row_t row;
    row = blank_row();
    row.it.op = op;
    row.fixed = 1'b1;
    return row;
  endfunction

  function automatic dir_row_t reg_row(pcdg_pkg::cfg_reg_t idx, int val);
    dir_row_t row;
    row = blank_row();
    row.is_cfg = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val[CDW-1:0];
    return row;
  endfunction

  task automatic send_item(input gate_item_t it, input bit fixed, input gate_verdict_t want);
    gate_verdict_t v;
    in_valid <= 1'b1;
    opcode <= it.op;
    cand_valid <= it.cvalid;
    cand_intercept <= it.ci;
    cand_slope_x <= it.sx;
    cand_slope_y <= it.sy;
    point_index <= it.slot;
    point_x <= it.px;
    point_y <= it.py;
    do @(posedge clk); while (in_stall !== 1'b0);
    v = plane_gate_step(it);
    if (fixed) v = want;
    pending_verdicts.push_back(v);
    items_sent++;
    act_tally[v.act]++;
    if (v.sat) sat_tally++;
  endtask

  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // Holds the input off until every pending result has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input pcdg_pkg::cfg_reg_t idx, input logic [CDW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    if (idx == pcdg_pkg::CFG_DEADBAND) db_reg = val[DW-1:0];
    else npts_reg = val[pcdg_pkg::COUNT_W-1:0];
    reg_writes++;
  endtask

  // Result side: check each transfer, then draw the stall for the next cycle.
  always @(posedge clk) begin
    gate_verdict_t want;
    if (rst) begin
      out_stall <= 1'b0;
      rx_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_verdicts.size() == 0) begin
          report_mismatch("result with nothing pending, action", DW'(action), '0);
        end else begin
          want = pending_verdicts.pop_front();
          if (action !== want.act)
            report_mismatch("action", DW'(action), DW'(want.act));
          if (max_delta !== want.delta)
            report_mismatch("max_delta", max_delta, want.delta);
          if (delta_saturated !== want.sat)
            report_mismatch("delta_saturated", DW'(delta_saturated), DW'(want.sat));
        end
      end
      if (rx_hold > 0) rx_hold--;
      else if (!quiet && $urandom_range(0, 7) == 0) rx_hold = $urandom_range(1, 11);
      out_stall <= (rx_hold > 0);
    end
  end

  initial begin
    gate_item_t it;
    gate_verdict_t none_v;
    int ph, i, cnt;
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = pcdg_pkg::OP_OBSERVE;
    cand_valid = 1'b0;
    cand_intercept = '0;
    cand_slope_x = '0;
    cand_slope_y = '0;
    point_index = '0;
    point_x = '0;
    point_y = '0;
    cfg_valid = 1'b0;
    cfg_index = pcdg_pkg::CFG_DEADBAND;
    cfg_data = '0;
    quiet = 1'b0;
    none_v = '{act: pcdg_pkg::ACT_NONE, delta: '0, sat: 1'b0};
    clear_plane();
    slot_loaded = '0;
    db_reg = '0;
    npts_reg = pcdg_pkg::POINT_COUNT_RST;
    foreach (tab_x[k]) begin
      tab_x[k] = 0;
      tab_y[k] = 0;
    end

    // Directed part, starting from the reset settings: deadband 0, four points.
    dir_rows.push_back(cand_row(0, 0, 0, 0, 1, pcdg_pkg::ACT_NONE, '0, 0));
    dir_rows.push_back(code_row(OP_UNDEFINED));
    dir_rows.push_back(code_row(pcdg_pkg::OP_RESET));
    dir_rows.push_back(load_row(0, 8191, -8192));
    dir_rows.push_back(load_row(1, -8192, 8191));
    dir_rows.push_back(load_row(2, 0, 0));
    dir_rows.push_back(load_row(3, 100, -37));
    dir_rows.push_back(cand_row(1, 8388607, -524288, 524287, 1, pcdg_pkg::ACT_RECALC, '0, 0));
    // Opposite extremes: the delta saturates at one of the points.
    dir_rows.push_back(cand_row(1, -8388608, 524287, -524288, 0, pcdg_pkg::ACT_NONE, '0, 0));
    // Zero deadband: even a zero delta recalculates.
    dir_rows.push_back(cand_row(1, -8388608, 524287, -524288, 1, pcdg_pkg::ACT_RECALC, '0, 0));
    dir_rows.push_back(cand_row(0, 0, 0, 0, 1, pcdg_pkg::ACT_FAIL_OPEN, '0, 0));
    dir_rows.push_back(cand_row(0, 0, 0, 0, 1, pcdg_pkg::ACT_NONE, '0, 0));
    dir_rows.push_back(cand_row(1, 0, 0, 0, 1, pcdg_pkg::ACT_RECALC, '0, 0));
    dir_rows.push_back(reg_row(pcdg_pkg::CFG_DEADBAND, 16777215));
    dir_rows.push_back(cand_row(1, 1000, 300, -200, 0, pcdg_pkg::ACT_NONE, '0, 0));
    dir_rows.push_back(cand_row(1, -8388608, 0, 0, 0, pcdg_pkg::ACT_NONE, '0, 0));
    dir_rows.push_back(code_row(pcdg_pkg::OP_RESET));
    dir_rows.push_back(cand_row(1, 5, 0, 0, 1, pcdg_pkg::ACT_RECALC, '0, 0));
    // No points in use: the delta is zero and stays under the largest deadband.
    dir_rows.push_back(reg_row(pcdg_pkg::CFG_POINT_COUNT, 0));
    dir_rows.push_back(cand_row(1, 8388607, 524287, 524287, 1, pcdg_pkg::ACT_REFRESH, '0, 0));
    dir_rows.push_back(reg_row(pcdg_pkg::CFG_POINT_COUNT, 1));
    dir_rows.push_back(reg_row(pcdg_pkg::CFG_DEADBAND, 1));
    dir_rows.push_back(cand_row(1, 21, 0, 0, 0, pcdg_pkg::ACT_NONE, '0, 0));
    dir_rows.push_back(load_row(15, 8191, 8191));
    dir_rows.push_back(load_row(14, -1, -1));
    dir_rows.push_back(cand_row(1, 21, 0, 0, 1, pcdg_pkg::ACT_REFRESH, '0, 0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].is_cfg) begin
        settle();
        write_reg(dir_rows[r].reg_idx, dir_rows[r].reg_val);
      end else begin
        send_item(dir_rows[r].it, dir_rows[r].fixed, dir_rows[r].want);
        sender_gap();
      end
    end

    // Random phases, each under its own register setting; the last one runs without idling.
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      quiet = (ph == RANDOM_PHASES - 1);
      case (ph)
        0: begin
          write_reg(pcdg_pkg::CFG_DEADBAND, CDW'($urandom_range(0, 3000)));
          cnt = 16;
        end
        1: begin
          write_reg(pcdg_pkg::CFG_DEADBAND, '0);
          cnt = 31;
        end
        2: begin
          write_reg(pcdg_pkg::CFG_DEADBAND, pcdg_pkg::DELTA_MAX);
          cnt = $urandom_range(1, 16);
        end
        3: begin
          write_reg(pcdg_pkg::CFG_DEADBAND, CDW'($urandom_range(0, 20000)));
          cnt = $urandom_range(0, 31);
        end
        default: begin
          write_reg(pcdg_pkg::CFG_DEADBAND, CDW'($urandom_range(0, 3000)));
          cnt = (ph == RANDOM_PHASES - 1) ? 4 : $urandom_range(1, 16);
        end
      endcase
      // The upper data bits are not part of the count and carry noise.
      write_reg(pcdg_pkg::CFG_POINT_COUNT, {19'($urandom), 5'(cnt)});
      for (i = 0; i < PHASE_ITEMS; i++) begin
        it = draw_item();
        send_item(it, 1'b0, none_v);
        sender_gap();
      end
    end

    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d items and %0d register writes: %0d none, %0d fail-open,",
             items_sent, reg_writes, act_tally[pcdg_pkg::ACT_NONE],
             act_tally[pcdg_pkg::ACT_FAIL_OPEN]);
    $display("%0d recalculate, %0d refresh-only, %0d saturated deltas; %0d mismatches.",
             act_tally[pcdg_pkg::ACT_RECALC], act_tally[pcdg_pkg::ACT_REFRESH], sat_tally,
             mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/pcdg_pkg.sv
sv/pcdg_ram.sv
sv/plane_change_deadband_gate_unit.sv
tb/sv/tb_plane_change_deadband_gate_unit.sv
